>>> hdl/cisp_pkg.sv
// ----------------------------------------------------------------------------
// cisp_pkg
// Types and constants shared by the image stream parser modules.
// ----------------------------------------------------------------------------
package cisp_pkg;

    typedef enum logic [3:0] {
        PH_MAGIC   = 4'd0,
        PH_HSIZE   = 4'd1,
        PH_CSIZE   = 4'd2,
        PH_WIDTH   = 4'd3,
        PH_HEIGHT  = 4'd4,
        PH_CAPTION = 4'd5,
        PH_TAGS    = 4'd6,
        PH_PIXELS  = 4'd7,
        PH_DONE    = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_CAPTION = 3'd1,
        KIND_TAG     = 3'd2,
        KIND_TAG_END = 3'd3,
        KIND_PIXEL   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_MAGIC    = 3'd1,
        ERR_SIZE     = 3'd2,
        ERR_TAG_NL   = 3'd3,
        ERR_CAPTION  = 3'd4
    } err_t;

    // Magic bytes "CIFF", first byte in the lowest lane.
    localparam logic [3:0][7:0] MAGIC_WORD = {8'h46, 8'h46, 8'h49, 8'h43};

    localparam logic [63:0] FIXED_HEADER_BYTES = 64'd36;
    localparam logic [7:0]  CHAR_NL            = 8'h0A;
    localparam logic [7:0]  CHAR_NUL           = 8'h00;
    localparam logic [2:0]  LAST_FIELD_BYTE    = 3'd7;
    localparam logic [2:0]  LAST_MAGIC_BYTE    = 3'd3;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        err_t       error;
        logic       image_end;
    } result_t;

endpackage

>>> hdl/ciff_image_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// ciff_image_stream_parser_unit
// Byte-serial image file parser with a registered, skid-buffered result port.
// ----------------------------------------------------------------------------
// Each result is registered, in the skid entry while the output is held.
// Throughput: one byte per cycle; the longest path is the 64x8 multiply-add
// that folds each height byte into the area product.
// The input side stalls only while the two-entry output buffer is full.
// Reset returns the parser to the magic check and empties the output buffer.
module ciff_image_stream_parser_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       start_of_file,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] byte_kind,
    output logic [7:0] byte_value,
    output logic [2:0] error_code,
    output logic       image_end
);

    cisp_pkg::result_t result;
    cisp_pkg::result_t out_data_reg, out_data_next;
    cisp_pkg::result_t skid_data_reg, skid_data_next;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic              accept;
    logic              out_free;

    assign accept   = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    cisp_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .result        (result)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_stall   = skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign byte_kind  = out_data_reg.kind;
    assign byte_value = out_data_reg.value;
    assign error_code = out_data_reg.error;
    assign image_end  = out_data_reg.image_end;

    // The skid entry is only ever filled behind a held output beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall && in_valid))
        else $error("skid entry filled without a stalled output");

    // A completed image never carries an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && image_end) |-> (error_code == cisp_pkg::ERR_NONE))
        else $error("image end reported together with an error");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (byte_kind == cisp_pkg::KIND_HEADER
                       || byte_kind == cisp_pkg::KIND_TAG_END)) |-> (byte_value == 8'h00))
        else $error("byte value not cleared for header or tag end beat");

endmodule

>>> hdl/cisp_parser.sv
// ----------------------------------------------------------------------------
// cisp_parser
// Parser state and the combinational update for one accepted file byte.
// ----------------------------------------------------------------------------
module cisp_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              start_of_file,
    output cisp_pkg::result_t result
);

    cisp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]       idx_reg, idx_next;
    logic [63:0]      hdr_len_reg, hdr_len_next;
    logic [63:0]      content_len_reg, content_len_next;
    logic [63:0]      width3_reg, width3_next;
    logic [63:0]      area_reg, area_next;
    logic [63:0]      hdr_cnt_reg, hdr_cnt_next;
    logic [63:0]      pix_cnt_reg, pix_cnt_next;
    logic             tag_open_reg, tag_open_next;
    cisp_pkg::err_t   err_reg, err_next;

    // State as seen by this beat: a start-of-file beat parses from reset values.
    cisp_pkg::phase_t cur_phase;
    logic [2:0]       cur_idx;
    logic [63:0]      cur_hdr_len;
    logic [63:0]      cur_content_len;
    logic [63:0]      cur_width3;
    logic [63:0]      cur_area;
    logic [63:0]      cur_hdr_cnt;
    logic [63:0]      cur_pix_cnt;
    logic             cur_tag_open;
    cisp_pkg::err_t   cur_err;

    logic [5:0]       shamt;
    logic [63:0]      byte_part;
    logic [9:0]       byte_x3;
    logic [63:0]      mul_full;
    logic [63:0]      area_sum;
    logic [31:0]      tag_diff;

    always_comb
    begin
        if (start_of_file)
        begin
            cur_phase       = cisp_pkg::PH_MAGIC;
            cur_idx         = '0;
            cur_hdr_len     = '0;
            cur_content_len = '0;
            cur_width3      = '0;
            cur_area        = '0;
            cur_hdr_cnt     = '0;
            cur_pix_cnt     = '0;
            cur_tag_open    = 1'b0;
            cur_err         = cisp_pkg::ERR_NONE;
        end
        else
        begin
            cur_phase       = phase_reg;
            cur_idx         = idx_reg;
            cur_hdr_len     = hdr_len_reg;
            cur_content_len = content_len_reg;
            cur_width3      = width3_reg;
            cur_area        = area_reg;
            cur_hdr_cnt     = hdr_cnt_reg;
            cur_pix_cnt     = pix_cnt_reg;
            cur_tag_open    = tag_open_reg;
            cur_err         = err_reg;
        end
    end

    // The width is kept pre-multiplied by three, and the height is folded in
    // one byte at a time, so each beat needs only a 64x8 product.
    assign shamt     = {cur_idx, 3'b000};
    assign byte_part = 64'(data_byte) << shamt;
    assign byte_x3   = {2'b00, data_byte} + {1'b0, data_byte, 1'b0};
    assign mul_full  = cur_width3 * 64'(data_byte);
    assign area_sum  = cur_area + (mul_full << shamt);
    // Header length minus the bytes through the caption newline, low 32 bits.
    assign tag_diff  = cur_hdr_len[31:0] + ~cur_hdr_cnt[31:0];

    always_comb
    begin
        phase_next       = cur_phase;
        idx_next         = cur_idx;
        hdr_len_next     = cur_hdr_len;
        content_len_next = cur_content_len;
        width3_next      = cur_width3;
        area_next        = cur_area;
        hdr_cnt_next     = cur_hdr_cnt;
        pix_cnt_next     = cur_pix_cnt;
        tag_open_next    = cur_tag_open;
        err_next         = cur_err;
        result.kind      = cisp_pkg::KIND_HEADER;
        result.value     = 8'h00;
        result.image_end = 1'b0;

        if (cur_err == cisp_pkg::ERR_NONE)
        begin
            case (cur_phase)
                cisp_pkg::PH_MAGIC:
                begin
                    if (data_byte != cisp_pkg::MAGIC_WORD[cur_idx[1:0]])
                    begin
                        err_next = cisp_pkg::ERR_MAGIC;
                    end
                    else if (cur_idx == cisp_pkg::LAST_MAGIC_BYTE)
                    begin
                        idx_next   = '0;
                        phase_next = cisp_pkg::PH_HSIZE;
                    end
                    else
                    begin
                        idx_next = cur_idx + 3'd1;
                    end
                end
                cisp_pkg::PH_HSIZE, cisp_pkg::PH_CSIZE,
                cisp_pkg::PH_WIDTH, cisp_pkg::PH_HEIGHT:
                begin
                    idx_next = cur_idx + 3'd1;
                    case (cur_phase)
                        cisp_pkg::PH_HSIZE: hdr_len_next = cur_hdr_len | byte_part;
                        cisp_pkg::PH_CSIZE: content_len_next = cur_content_len | byte_part;
                        cisp_pkg::PH_WIDTH:
                            width3_next = cur_width3 + (64'(byte_x3) << shamt);
                        default: area_next = area_sum;
                    endcase
                    if (cur_idx == cisp_pkg::LAST_FIELD_BYTE)
                    begin
                        case (cur_phase)
                            cisp_pkg::PH_HSIZE: phase_next = cisp_pkg::PH_CSIZE;
                            cisp_pkg::PH_CSIZE: phase_next = cisp_pkg::PH_WIDTH;
                            cisp_pkg::PH_WIDTH: phase_next = cisp_pkg::PH_HEIGHT;
                            default:
                            begin
                                if (area_sum != cur_content_len)
                                begin
                                    err_next = cisp_pkg::ERR_SIZE;
                                end
                                else
                                begin
                                    hdr_cnt_next = cisp_pkg::FIXED_HEADER_BYTES;
                                    phase_next   = cisp_pkg::PH_CAPTION;
                                end
                            end
                        endcase
                    end
                end
                cisp_pkg::PH_CAPTION:
                begin
                    hdr_cnt_next = cur_hdr_cnt + 64'd1;
                    if (cur_hdr_cnt >= cur_hdr_len)
                    begin
                        err_next = cisp_pkg::ERR_CAPTION;
                    end
                    else if (data_byte == cisp_pkg::CHAR_NL)
                    begin
                        hdr_cnt_next  = {32'h0, tag_diff};
                        tag_open_next = 1'b0;
                        if (tag_diff == 32'h0)
                        begin
                            pix_cnt_next = cur_content_len;
                            if (cur_content_len == 64'd0)
                            begin
                                phase_next       = cisp_pkg::PH_DONE;
                                result.image_end = 1'b1;
                            end
                            else
                            begin
                                phase_next = cisp_pkg::PH_PIXELS;
                            end
                        end
                        else
                        begin
                            phase_next = cisp_pkg::PH_TAGS;
                        end
                    end
                    else
                    begin
                        result.kind  = cisp_pkg::KIND_CAPTION;
                        result.value = data_byte;
                    end
                end
                cisp_pkg::PH_TAGS:
                begin
                    if (data_byte == cisp_pkg::CHAR_NL)
                    begin
                        err_next = cisp_pkg::ERR_TAG_NL;
                    end
                    else
                    begin
                        if (data_byte == cisp_pkg::CHAR_NUL)
                        begin
                            if (cur_tag_open)
                            begin
                                result.kind   = cisp_pkg::KIND_TAG_END;
                                tag_open_next = 1'b0;
                            end
                        end
                        else
                        begin
                            result.kind   = cisp_pkg::KIND_TAG;
                            result.value  = data_byte;
                            tag_open_next = 1'b1;
                        end
                        hdr_cnt_next = cur_hdr_cnt - 64'd1;
                        // An unfinished tag at the end of the region is dropped.
                        if (cur_hdr_cnt == 64'd1)
                        begin
                            tag_open_next = 1'b0;
                            pix_cnt_next  = cur_content_len;
                            if (cur_content_len == 64'd0)
                            begin
                                phase_next       = cisp_pkg::PH_DONE;
                                result.image_end = 1'b1;
                            end
                            else
                            begin
                                phase_next = cisp_pkg::PH_PIXELS;
                            end
                        end
                    end
                end
                cisp_pkg::PH_PIXELS:
                begin
                    result.kind  = cisp_pkg::KIND_PIXEL;
                    result.value = data_byte;
                    pix_cnt_next = cur_pix_cnt - 64'd1;
                    if (cur_pix_cnt == 64'd1)
                    begin
                        phase_next       = cisp_pkg::PH_DONE;
                        result.image_end = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        result.error = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= cisp_pkg::PH_MAGIC;
            idx_reg         <= '0;
            hdr_len_reg     <= '0;
            content_len_reg <= '0;
            width3_reg      <= '0;
            area_reg        <= '0;
            hdr_cnt_reg     <= '0;
            pix_cnt_reg     <= '0;
            tag_open_reg    <= 1'b0;
            err_reg         <= cisp_pkg::ERR_NONE;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            idx_reg         <= idx_next;
            hdr_len_reg     <= hdr_len_next;
            content_len_reg <= content_len_next;
            width3_reg      <= width3_next;
            area_reg        <= area_next;
            hdr_cnt_reg     <= hdr_cnt_next;
            pix_cnt_reg     <= pix_cnt_next;
            tag_open_reg    <= tag_open_next;
            err_reg         <= err_next;
        end
    end

endmodule

>>> verif/ciff_image_stream_parser_unit_test.sv
// ----------------------------------------------------------------------------
// ciff_image_stream_parser_unit_test
// Self-checking bench for the byte-serial image file parser. A byte-level model of
// the parser predicts the result of every accepted byte. Each result beat is
// compared field by field in arrival order. The stimulus is mostly complete
// files with random content, mixed with broken and cut-off files, and both
// ports see random idle and stall bursts.
// ----------------------------------------------------------------------------
module ciff_image_stream_parser_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cisp_pkg::*;

    localparam int          TARGET_BYTES = 1850;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          CYCLE_LIMIT  = 500000;
    localparam logic [63:0] PIXEL_BYTES  = 64'd3;

    typedef enum int {
        FILE_CLEAN      = 0,
        FILE_WRAPPED    = 1,
        FILE_BIG_HEADER = 2,
        FILE_NO_TAGS    = 3,
        FILE_UNCLOSED   = 4,
        FILE_TAG_NL     = 5,
        FILE_OVERRUN    = 6,
        FILE_SIZE_BAD   = 7,
        FILE_BAD_MAGIC  = 8,
        FILE_CUT        = 9
    } file_shape_t;

    // Short opening sequence: {start_of_file, byte}. It breaks the magic at
    // each of its four positions, restarts in the middle of the magic, and
    // drives the all-zero and all-one byte values.
    localparam logic [8:0] OPENING [19] = '{
        {1'b1, 8'hFF}, {1'b0, 8'h00},
        {1'b1, 8'h43}, {1'b0, 8'h00},
        {1'b1, 8'h43}, {1'b0, 8'h49}, {1'b0, 8'hFF},
        {1'b1, 8'h43}, {1'b0, 8'h49}, {1'b0, 8'h46}, {1'b0, 8'h47},
        {1'b1, 8'h43}, {1'b1, 8'h43}, {1'b0, 8'h49}, {1'b0, 8'h46}, {1'b0, 8'h46},
        {1'b0, 8'h00}, {1'b1, 8'h00}, {1'b0, 8'hFF}
    };

    class parse_tracker;
        phase_t      phase;
        logic [2:0]  field_idx;
        logic [63:0] hdr_len;
        logic [63:0] content_len;
        logic [63:0] img_width;
        logic [63:0] area;
        logic [63:0] hdr_count;
        logic [63:0] px_left;
        logic        tag_open;
        err_t        err;
        result_t     due_results[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            phase       = PH_MAGIC;
            field_idx   = '0;
            hdr_len     = '0;
            content_len = '0;
            img_width   = '0;
            area        = '0;
            hdr_count   = '0;
            px_left     = '0;
            tag_open    = 1'b0;
            err         = ERR_NONE;
        endfunction

        function logic leave_header();
            px_left = content_len;
            if (px_left == 64'd0)
            begin
                phase = PH_DONE;
                return 1'b1;
            end
            phase = PH_PIXELS;
            return 1'b0;
        endfunction

        function void take_byte(logic [7:0] b, logic sof);
            result_t     r;
            logic [63:0] part;
            logic [63:0] diff;
            r.kind      = KIND_HEADER;
            r.value     = 8'h00;
            r.image_end = 1'b0;
            if (sof)
                restart();
            if (err == ERR_NONE)
            begin
                case (phase)
                    PH_MAGIC:
                    begin
                        if (b != MAGIC_WORD[field_idx[1:0]])
                            err = ERR_MAGIC;
                        else if (field_idx == LAST_MAGIC_BYTE)
                        begin
                            field_idx = '0;
                            phase     = PH_HSIZE;
                        end
                        else
                            field_idx = field_idx + 3'd1;
                    end
                    PH_HSIZE, PH_CSIZE, PH_WIDTH, PH_HEIGHT:
                    begin
                        part = {56'h0, b} << (8 * field_idx);
                        case (phase)
                            PH_HSIZE: hdr_len     = hdr_len | part;
                            PH_CSIZE: content_len = content_len | part;
                            PH_WIDTH: img_width   = img_width | part;
                            default:  area        = area | part;
                        endcase
                        if (field_idx == LAST_FIELD_BYTE)
                        begin
                            field_idx = '0;
                            if (phase == PH_HEIGHT)
                            begin
                                // The product wraps at 64 bits.
                                area = img_width * area * PIXEL_BYTES;
                                if (area != content_len)
                                    err = ERR_SIZE;
                                else
                                begin
                                    hdr_count = FIXED_HEADER_BYTES;
                                    phase     = PH_CAPTION;
                                end
                            end
                            else
                                phase = phase_t'(phase + 1);
                        end
                        else
                            field_idx = field_idx + 3'd1;
                    end
                    PH_CAPTION:
                    begin
                        hdr_count = hdr_count + 64'd1;
                        if (hdr_count > hdr_len)
                            err = ERR_CAPTION;
                        else if (b == CHAR_NL)
                        begin
                            // From here on the count holds the tag bytes still to
                            // come, kept to 32 bits.
                            diff      = hdr_len - hdr_count;
                            hdr_count = {32'h0, diff[31:0]};
                            tag_open  = 1'b0;
                            if (hdr_count == 64'd0)
                                r.image_end = leave_header();
                            else
                                phase = PH_TAGS;
                        end
                        else
                        begin
                            r.kind  = KIND_CAPTION;
                            r.value = b;
                        end
                    end
                    PH_TAGS:
                    begin
                        if (b == CHAR_NL)
                            err = ERR_TAG_NL;
                        else
                        begin
                            if (b == CHAR_NUL)
                            begin
                                if (tag_open)
                                begin
                                    r.kind   = KIND_TAG_END;
                                    tag_open = 1'b0;
                                end
                            end
                            else
                            begin
                                r.kind   = KIND_TAG;
                                r.value  = b;
                                tag_open = 1'b1;
                            end
                            hdr_count = hdr_count - 64'd1;
                            if (hdr_count == 64'd0)
                            begin
                                tag_open    = 1'b0;
                                r.image_end = leave_header();
                            end
                        end
                    end
                    PH_PIXELS:
                    begin
                        r.kind   = KIND_PIXEL;
                        r.value  = b;
                        px_left  = px_left - 64'd1;
                        if (px_left == 64'd0)
                        begin
                            phase       = PH_DONE;
                            r.image_end = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            r.error = err;
            due_results.insert(due_results.size(), r);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(kind_t kind, logic [7:0] value, err_t error, logic img_end);
            result_t want;
            if (due_results.size() == 0)
            begin
                report($sformatf("unexpected beat: kind %0d value %02h error %0d end %0b",
                                 kind, value, error, img_end));
                return;
            end
            want = due_results.pop_front();
            if (kind != want.kind)
                report($sformatf("byte_kind %0d, want %0d", kind, want.kind));
            if (value != want.value)
                report($sformatf("byte_value %02h, want %02h", value, want.value));
            if (error != want.error)
                report($sformatf("error_code %0d, want %0d", error, want.error));
            if (img_end != want.image_end)
                report($sformatf("image_end %0b, want %0b", img_end, want.image_end));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid      = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte     = 8'h00;
    logic       start_of_file = 1'b0;
    logic       out_valid;
    logic       out_stall     = 1'b0;
    logic [2:0] byte_kind;
    logic [7:0] byte_value;
    logic [2:0] error_code;
    logic       image_end;

    parse_tracker tracker      = new();
    logic [7:0]   file_bytes[$];
    bit           calm         = 1'b0;
    bit           hold_request = 1'b0;
    int unsigned  cycle_count  = 0;

    ciff_image_stream_parser_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .byte_kind     (byte_kind),
        .byte_value    (byte_value),
        .error_code    (error_code),
        .image_end     (image_end)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // The low level is scheduled so that the asynchronous reset sees a falling edge.
    initial
    begin
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("ciff_image_stream_parser_unit regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(kind_t'(byte_kind), byte_value, err_t'(error_code),
                                 image_end);
    end

    // Result side: stall bursts, free-running stretches, and one long hold that
    // backs the parser up until it stalls its input.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat (calm ? 1 : $urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    function automatic logic [7:0] text_char(bit no_nul);
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (c == CHAR_NL || (no_nul && c == CHAR_NUL));
        return c;
    endfunction

    function automatic void add_byte(logic [7:0] b);
        file_bytes.insert(file_bytes.size(), b);
    endfunction

    function automatic void put_word(logic [63:0] v);
        for (int i = 0; i < 8; i++)
            add_byte(v[8*i +: 8]);
    endfunction

    // Builds one file in file_bytes and returns the number of bytes that the
    // parser is meant to look at; any trailing junk after that is ignored.
    function automatic int build_file(file_shape_t shape);
        logic [7:0]  caption[$];
        logic [7:0]  tags[$];
        logic [63:0] w;
        logic [63:0] h;
        logic [63:0] content;
        logic [63:0] hlen;
        logic [63:0] pixel_count;
        int          useful;
        file_bytes.delete();
        w = 64'($urandom_range(0, 4));
        h = 64'($urandom_range(0, 3));
        repeat ($urandom_range(0, 6)) caption.insert(caption.size(), text_char(1'b0));
        if (shape != FILE_NO_TAGS)
        begin
            // Tags of length zero are empty tags and must be skipped.
            repeat ($urandom_range(1, 3))
            begin
                repeat ($urandom_range(0, 4)) tags.insert(tags.size(), text_char(1'b1));
                tags.insert(tags.size(), CHAR_NUL);
            end
        end
        case (shape)
            FILE_WRAPPED:
            begin
                if ($urandom_range(0, 1))
                begin
                    w = 64'h8000_0000_0000_0000;
                    h = 64'd2;
                end
                else
                begin
                    w = 64'd1;
                    h = 64'h5555_5555_5555_5556;
                end
            end
            FILE_UNCLOSED:
                repeat ($urandom_range(1, 3)) tags.insert(tags.size(), text_char(1'b1));
            FILE_TAG_NL:   tags.insert($urandom_range(0, tags.size() - 1), CHAR_NL);
            default:
            begin
            end
        endcase
        content = w * h * PIXEL_BYTES;
        hlen    = FIXED_HEADER_BYTES + 64'(caption.size()) + 64'd1 + 64'(tags.size());
        case (shape)
            FILE_BIG_HEADER: hlen = hlen + {32'($urandom), 32'h0};
            FILE_OVERRUN:    hlen = 64'($urandom_range(0, 36 + caption.size()));
            FILE_SIZE_BAD:   content = content ^ (64'd1 << $urandom_range(0, 63));
            default:
            begin
            end
        endcase
        for (int i = 0; i < 4; i++)
            add_byte(MAGIC_WORD[i]);
        put_word(hlen);
        put_word(content);
        put_word(w);
        put_word(h);
        foreach (caption[i])
            add_byte(caption[i]);
        add_byte(CHAR_NL);
        foreach (tags[i])
            add_byte(tags[i]);
        pixel_count = (shape == FILE_SIZE_BAD) ? 64'($urandom_range(0, 4)) : content;
        repeat (pixel_count) add_byte(8'($urandom));
        if (shape == FILE_BAD_MAGIC)
            file_bytes[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
        if (shape == FILE_CUT)
            file_bytes = file_bytes[0 : $urandom_range(0, file_bytes.size() - 2)];
        useful = file_bytes.size();
        repeat ($urandom_range(0, 2)) add_byte(8'($urandom));
        return useful;
    endfunction

    task automatic send_beat(logic [7:0] b, logic sof);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        start_of_file <= sof;
        do
            @(posedge clk);
        while (in_stall);
        tracker.take_byte(b, sof);
    endtask

    initial
    begin
        int          sent;
        int unsigned pick;
        bit          hold_done;
        sent      = 0;
        hold_done = 1'b0;
        wait (rst_n);
        @(posedge clk);
        foreach (OPENING[i])
            send_beat(OPENING[i][7:0], OPENING[i][8]);
        while (sent < TARGET_BYTES)
        begin
            pick = $urandom_range(0, 15);
            sent += build_file((pick > FILE_CUT) ? FILE_CLEAN : file_shape_t'(pick));
            foreach (file_bytes[i])
                send_beat(file_bytes[i], i == 0);
            if (!hold_done && sent > 400)
            begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            calm = sent > TARGET_BYTES * 85 / 100;
        end
        in_valid <= 1'b0;
        while (tracker.due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("ciff_image_stream_parser_unit regression: pass");
        else
            $display("ciff_image_stream_parser_unit regression: fail");
        $finish;
    end

endmodule
